// ===== design/first_match_flow_classifier_top_defines.svh =====
// Assertion macros used by the checker module of the classifier.
`ifndef FIRST_MATCH_FLOW_CLASSIFIER_TOP_DEFINES_SVH
`define FIRST_MATCH_FLOW_CLASSIFIER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMFC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fmfc_pkg.sv =====
package fmfc_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   localparam logic CMD_APPEND   = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   localparam logic [1:0] KIND_DSCP  = 2'd0;
   localparam logic [1:0] KIND_PORT  = 2'd1;
   localparam logic [1:0] KIND_LABEL = 2'd2;

   localparam int CSR_ADDR_W        = 3;
   localparam int REG_DEFAULT_SLICE = 0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  dscp;
      logic [15:0] port_lo;
      logic [15:0] port_hi;
      logic        label_present;
      logic [31:0] label;
      logic [31:0] slice_value;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   typedef struct packed {
      logic [31:0] slice_out;
      logic        hit;
      logic [5:0]  hit_index;
      logic [6:0]  rules_held;
      logic        table_full;
   } result_type;

   function automatic logic rule_hits(rule_type r, logic [5:0] dscp, logic [15:0] port,
                                      logic [31:0] label);
      logic h;
      case (r.kind)
         KIND_DSCP:  h = (r.dscp == dscp);
         KIND_PORT:  h = (port >= r.port_lo) && (port <= r.port_hi);
         KIND_LABEL: h = r.label_present && (r.label == label);
         default:    h = 1'b0;
      endcase
      return h;
   endfunction

endpackage

// ===== design/fmfc_req_if.sv =====
interface fmfc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [1:0]  rule_kind;
   logic [5:0]  dscp;
   logic [15:0] port_lo;
   logic [15:0] port_hi;
   logic [15:0] dst_port;
   logic [31:0] label;
   logic        label_present;
   logic [31:0] slice_value;

   modport source (
      output valid, cmd, rule_kind, dscp, port_lo, port_hi, dst_port, label,
             label_present, slice_value,
      input  ready
   );

   modport sink (
      input  valid, cmd, rule_kind, dscp, port_lo, port_hi, dst_port, label,
             label_present, slice_value,
      output ready
   );
endinterface

// ===== design/fmfc_rsp_if.sv =====
interface fmfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] slice_out;
   logic        hit;
   logic [5:0]  hit_index;
   logic [6:0]  rules_held;
   logic        table_full;

   modport source (
      output valid, slice_out, hit, hit_index, rules_held, table_full,
      input  ready
   );

   modport sink (
      input  valid, slice_out, hit, hit_index, rules_held, table_full,
      output ready
   );
endinterface

// ===== design/fmfc_ram.sv =====
module fmfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic                                          re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/first_match_flow_classifier_top.sv =====
// Append or classify on an empty table: the result goes straight to the response state and loads
// into the output register once that register is free. Classify: the rule memory is read one rule
// per cycle, and the scan stops at the first hit or after the last rule held, before the response state.
// One item is in work at a time; the next beat can be taken in the cycle after the result loads into
// the output register, and a stalled result port holds the finished result and the block.
// Synchronous reset empties the table and clears the default slice to zero.
module first_match_flow_classifier_top #(
   parameter int MAX_RULES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   fmfc_req_if.sink                        req_bus,
   fmfc_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fmfc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CW = $clog2(MAX_RULES + 1);

   fmfc_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [31:0]          default_ff, default_in;
   logic [5:0]           dscp_ff, dscp_in;
   logic [15:0]          port_ff, port_in;
   logic [31:0]          label_ff, label_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   fmfc_pkg::result_type res_ff, res_in;
   logic                 out_valid_ff, out_valid_in;
   fmfc_pkg::result_type out_ff, out_in;

   logic                 req_fire;
   logic                 is_full;
   logic                 ram_we;
   logic                 rd_en;
   logic                 hit_now;
   logic                 scan_last;
   logic                 out_free;
   logic                 csr_write;
   fmfc_pkg::rule_type   new_rule;
   fmfc_pkg::rule_type   ram_q;
   logic [fmfc_pkg::RULE_W-1:0] ram_rdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[fmfc_pkg::CSR_ADDR_W-1:2] ==
                       1'(fmfc_pkg::REG_DEFAULT_SLICE)) ? default_ff : 32'd0;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign is_full   = (count_ff == CW'(MAX_RULES));
   assign ram_q     = fmfc_pkg::rule_type'(ram_rdata);
   assign hit_now   = chk_valid_ff &&
                      fmfc_pkg::rule_hits(ram_q, dscp_ff, port_ff, label_ff);
   assign scan_last = chk_valid_ff && (issue_ff == count_ff);
   assign out_free  = !out_valid_ff || rsp_bus.ready;

   assign new_rule.kind          = req_bus.rule_kind;
   assign new_rule.dscp          = req_bus.dscp;
   assign new_rule.port_lo       = req_bus.port_lo;
   assign new_rule.port_hi       = req_bus.port_hi;
   assign new_rule.label_present = req_bus.label_present;
   assign new_rule.label         = req_bus.label;
   assign new_rule.slice_value   = req_bus.slice_value;

   fmfc_ram #(
      .WIDTH (fmfc_pkg::RULE_W),
      .DEPTH (MAX_RULES)
   ) u_rule_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (new_rule),
      .re    (rd_en),
      .raddr (issue_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmfc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.cmd == fmfc_pkg::CMD_APPEND || count_ff == '0) begin
                  state_in = fmfc_pkg::ST_RESP;
               end else begin
                  state_in = fmfc_pkg::ST_SCAN;
               end
            end
         end
         fmfc_pkg::ST_SCAN: begin
            if (hit_now || scan_last) begin
               state_in = fmfc_pkg::ST_RESP;
            end
         end
         fmfc_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = fmfc_pkg::ST_IDLE;
            end
         end
         default: state_in = fmfc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      ram_we        = 1'b0;
      case (state_ff)
         fmfc_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            ram_we        = req_bus.valid && req_bus.cmd == fmfc_pkg::CMD_APPEND && !is_full;
         end
         fmfc_pkg::ST_SCAN: begin
            rd_en = (issue_ff < count_ff) && !hit_now;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      default_in   = default_ff;
      dscp_in      = dscp_ff;
      port_in      = port_ff;
      label_in     = label_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (csr_write && paddr[fmfc_pkg::CSR_ADDR_W-1:2] == 1'(fmfc_pkg::REG_DEFAULT_SLICE)) begin
         default_in = pwdata;
      end

      if (state_ff == fmfc_pkg::ST_IDLE && req_fire) begin
         dscp_in  = req_bus.dscp;
         port_in  = req_bus.dst_port;
         label_in = req_bus.label;
         issue_in = '0;
         if (req_bus.cmd == fmfc_pkg::CMD_APPEND) begin
            if (!is_full) begin
               count_in = count_ff + CW'(1);
            end
            res_in.slice_out  = 32'd0;
            res_in.hit        = 1'b0;
            res_in.hit_index  = 6'd0;
            res_in.rules_held = 7'(count_in);
            res_in.table_full = is_full;
         end else begin
            res_in.slice_out  = default_ff;
            res_in.hit        = 1'b0;
            res_in.hit_index  = 6'd0;
            res_in.rules_held = 7'(count_ff);
            res_in.table_full = 1'b0;
         end
      end

      if (state_ff == fmfc_pkg::ST_SCAN) begin
         if (rd_en) begin
            issue_in     = issue_ff + CW'(1);
            chk_valid_in = 1'b1;
            chk_idx_in   = issue_ff[AW-1:0];
         end
         if (hit_now) begin
            res_in.slice_out = ram_q.slice_value;
            res_in.hit       = 1'b1;
            res_in.hit_index = 6'(chk_idx_ff);
         end
      end

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == fmfc_pkg::ST_RESP && out_free) begin
         out_valid_in = 1'b1;
         out_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmfc_pkg::ST_IDLE;
         count_ff     <= '0;
         default_ff   <= 32'd0;
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         default_ff   <= default_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dscp_ff    <= dscp_in;
      port_ff    <= port_in;
      label_ff   <= label_in;
      chk_idx_ff <= chk_idx_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.slice_out  = out_ff.slice_out;
   assign rsp_bus.hit        = out_ff.hit;
   assign rsp_bus.hit_index  = out_ff.hit_index;
   assign rsp_bus.rules_held = out_ff.rules_held;
   assign rsp_bus.table_full = out_ff.table_full;
endmodule

// ===== design/fmfc_checker.sv =====
`include "first_match_flow_classifier_top_defines.svh"

module fmfc_checker #(
   parameter int MAX_RULES = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       hit,
   input logic [5:0] hit_index,
   input logic [6:0] rules_held,
   input logic       table_full
);
   `FMFC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")
   `FMFC_ASSERT_IMPLY(a_hit_not_full, clock, reset, rsp_valid && hit, !table_full, "hit and table_full both set")
   `FMFC_ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && table_full, rules_held == 7'(MAX_RULES), "rejected append with table not at capacity")
   `FMFC_ASSERT_IMPLY(a_miss_index, clock, reset, rsp_valid && !hit, hit_index == 6'd0, "nonzero hit_index without a hit")
endmodule

bind first_match_flow_classifier_top fmfc_checker #(
   .MAX_RULES (MAX_RULES)
) u_fmfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .hit        (rsp_bus.hit),
   .hit_index  (rsp_bus.hit_index),
   .rules_held (rsp_bus.rules_held),
   .table_full (rsp_bus.table_full)
);

// ===== tb/sv/tb_first_match_flow_classifier_top.sv =====
module tb_first_match_flow_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;

   typedef struct {
      logic        cmd;
      logic [1:0]  rule_kind;
      logic [5:0]  dscp;
      logic [15:0] port_lo;
      logic [15:0] port_hi;
      logic [15:0] dst_port;
      logic [31:0] label;
      logic        label_present;
      logic [31:0] slice_value;
   } flow_beat_type;

   class slice_scoreboard;
      fmfc_pkg::rule_type   rule_table[TABLE_DEPTH];
      int unsigned          held = 0;
      logic [31:0]          default_slice = '0;
      fmfc_pkg::result_type slices_due[$];
      int unsigned          mismatches = 0;

      function void note_request(flow_beat_type b);
         fmfc_pkg::result_type want;
         fmfc_pkg::rule_type   r;
         bit                   found;
         int unsigned          i;
         want = '0;
         if (b.cmd == fmfc_pkg::CMD_APPEND) begin
            if (held >= TABLE_DEPTH) begin
               want.table_full = 1'b1;
            end else begin
               r.kind          = b.rule_kind;
               r.dscp          = b.dscp;
               r.port_lo       = b.port_lo;
               r.port_hi       = b.port_hi;
               r.label_present = b.label_present;
               r.label         = b.label;
               r.slice_value   = b.slice_value;
               rule_table[held] = r;
               held++;
            end
         end else begin
            want.slice_out = default_slice;
            found = 1'b0;
            for (i = 0; i < held && !found; i++) begin
               r = rule_table[i];
               case (r.kind)
                  fmfc_pkg::KIND_DSCP:  found = (r.dscp == b.dscp);
                  fmfc_pkg::KIND_PORT:  found = (b.dst_port >= r.port_lo) &&
                                                (b.dst_port <= r.port_hi);
                  fmfc_pkg::KIND_LABEL: found = r.label_present && (r.label == b.label);
                  default:              found = 1'b0;
               endcase
               if (found) begin
                  want.slice_out = r.slice_value;
                  want.hit       = 1'b1;
                  want.hit_index = i[5:0];
               end
            end
         end
         want.rules_held = held[6:0];
         slices_due.insert(slices_due.size(), want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(fmfc_pkg::result_type got);
         fmfc_pkg::result_type want;
         if (slices_due.size() == 0) begin
            $error("result beat arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = slices_due.pop_front();
         compare_field("slice_out", want.slice_out, got.slice_out);
         compare_field("hit", want.hit, got.hit);
         compare_field("hit_index", want.hit_index, got.hit_index);
         compare_field("rules_held", want.rules_held, got.rules_held);
         compare_field("table_full", want.table_full, got.table_full);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [fmfc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   bit          steady_flow = 1'b0;

   slice_scoreboard slice_check = new;

   fmfc_req_if req_bus ();
   fmfc_rsp_if rsp_bus ();

   first_match_flow_classifier_top #(
      .MAX_RULES (TABLE_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic flow_beat_type make_beat(logic cmd, logic [1:0] kind, logic [5:0] dscp,
                                               logic [15:0] lo, logic [15:0] hi,
                                               logic [15:0] dport, logic [31:0] label,
                                               logic lpres, logic [31:0] slice);
      flow_beat_type b;
      b.cmd           = cmd;
      b.rule_kind     = kind;
      b.dscp          = dscp;
      b.port_lo       = lo;
      b.port_hi       = hi;
      b.dst_port      = dport;
      b.label         = label;
      b.label_present = lpres;
      b.slice_value   = slice;
      return b;
   endfunction

   function automatic flow_beat_type random_beat();
      flow_beat_type      b;
      fmfc_pkg::rule_type r;
      int unsigned        roll;
      int unsigned        span;
      b = make_beat(fmfc_pkg::CMD_CLASSIFY, 2'($urandom_range(0, 3)), 6'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'($urandom),
                    $urandom);
      roll = $urandom_range(0, 99);
      if ((slice_check.held < TABLE_DEPTH && roll < 70) || roll < 5) begin
         b.cmd = fmfc_pkg::CMD_APPEND;
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            b.rule_kind = fmfc_pkg::KIND_DSCP;
         end else if (roll < 40) begin
            b.rule_kind = fmfc_pkg::KIND_PORT;
            if ($urandom_range(0, 9) != 0) begin
               span = $urandom_range(0, 200);
               b.port_hi = (b.port_lo + span > 65535) ? 16'hFFFF : 16'(b.port_lo + span);
            end
         end else if (roll < 90) begin
            b.rule_kind = fmfc_pkg::KIND_LABEL;
            b.label_present = ($urandom_range(0, 9) != 0);
         end else begin
            b.rule_kind = 2'd3;
         end
      end else if (slice_check.held > 0 && $urandom_range(0, 9) < 7) begin
         r = slice_check.rule_table[$urandom_range(0, slice_check.held - 1)];
         case (r.kind)
            fmfc_pkg::KIND_DSCP:  b.dscp = r.dscp;
            fmfc_pkg::KIND_PORT:  if (r.port_lo <= r.port_hi)
                                     b.dst_port = 16'($urandom_range(r.port_lo, r.port_hi));
            fmfc_pkg::KIND_LABEL: b.label = r.label;
            default:              b.dscp = r.dscp;
         endcase
      end
      return b;
   endfunction

   task automatic send_beat(flow_beat_type b);
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.cmd           = b.cmd;
      req_bus.rule_kind     = b.rule_kind;
      req_bus.dscp          = b.dscp;
      req_bus.port_lo       = b.port_lo;
      req_bus.port_hi       = b.port_hi;
      req_bus.dst_port      = b.dst_port;
      req_bus.label         = b.label;
      req_bus.label_present = b.label_present;
      req_bus.slice_value   = b.slice_value;
      req_bus.valid         = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      slice_check.note_request(b);
      @(negedge clock);
   endtask

   task automatic write_default_slice(logic [31:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = fmfc_pkg::CSR_ADDR_W'(fmfc_pkg::REG_DEFAULT_SLICE * 4);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      slice_check.default_slice = value;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (slice_check.slices_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned n;
      logic [31:0] settings[4];
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = fmfc_pkg::CMD_APPEND;
      req_bus.rule_kind     = fmfc_pkg::KIND_DSCP;
      req_bus.dscp          = '0;
      req_bus.port_lo       = '0;
      req_bus.port_hi       = '0;
      req_bus.dst_port      = '0;
      req_bus.label         = '0;
      req_bus.label_present = 1'b0;
      req_bus.slice_value   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_default_slice(32'hFFFF_FFFF);
      // A classify on the empty table falls through to the default slice.
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd63, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_DSCP, 6'd63, 16'h0, 16'h0,
                          16'h0, 32'h0, 1'b0, 32'h1100_0001));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_PORT, 6'd0, 16'h0, 16'h0,
                          16'h0, 32'h0, 1'b0, 32'h2200_0002));
      // The lower bound above the upper bound gives a range that never hits.
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_PORT, 6'd5, 16'hFFFF, 16'h0,
                          16'h0, 32'h0, 1'b0, 32'h3300_0003));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_LABEL, 6'd5, 16'h0, 16'h0,
                          16'h0, 32'hDEAD_BEEF, 1'b0, 32'h4400_0004));
      // Kind three takes a slot but never hits, even with everything else matching.
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, 2'd3, 6'd0, 16'h0, 16'hFFFF, 16'h0, 32'h0,
                          1'b1, 32'h5500_0005));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_LABEL, 6'd0, 16'h0, 16'h0,
                          16'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_PORT, 6'd0, 16'hFFFF, 16'hFFFF,
                          16'h0, 32'h0, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_LABEL, 6'd0, 16'h0, 16'h0,
                          16'h0, 32'h0, 1'b1, 32'h8800_0008));
      send_beat(make_beat(fmfc_pkg::CMD_APPEND, fmfc_pkg::KIND_DSCP, 6'd0, 16'h0, 16'h0,
                          16'h0, 32'h0, 1'b0, 32'h9900_0009));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd63, 16'h0, 16'h0,
                          16'd300, 32'h7, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd0, 16'h0, 16'h0,
                          16'h0, 32'h7, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd1, 16'h0, 16'h0,
                          16'd1, 32'hDEAD_BEEF, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd5, 16'h0, 16'h0,
                          16'hFFFF, 32'h5, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd5, 16'h0, 16'h0,
                          16'd300, 32'hFFFF_FFFF, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd5, 16'h0, 16'h0,
                          16'd300, 32'h0, 1'b0, 32'h0));
      send_beat(make_beat(fmfc_pkg::CMD_CLASSIFY, fmfc_pkg::KIND_DSCP, 6'd0, 16'h0, 16'h0,
                          16'd300, 32'h7, 1'b0, 32'h0));
      drain_results();

      settings[0] = 32'h0;
      settings[1] = $urandom;
      settings[2] = 32'hFFFF_FFFF;
      settings[3] = $urandom;
      foreach (settings[p]) begin
         write_default_slice(settings[p]);
         for (n = 0; n < 385; n++) begin
            if (n % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            send_beat(random_beat());
         end
         drain_results();
      end

      repeat (80) @(posedge clock);
      if (slice_check.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      int unsigned gap;
      int unsigned run;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         run = $urandom_range(1, 8);
         repeat (run - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      fmfc_pkg::result_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.slice_out  = rsp_bus.slice_out;
         seen.hit        = rsp_bus.hit;
         seen.hit_index  = rsp_bus.hit_index;
         seen.rules_held = rsp_bus.rules_held;
         seen.table_full = rsp_bus.table_full;
         slice_check.check_result(seen);
      end
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
